// ===== src/cfe_pkg.sv =====
package cfe_pkg;

  // Field widths of the request and result channels
  localparam int unsigned FieldW = 32;

  // Default width of the working dividend and divisor
  localparam int unsigned DefaultWidth = 32;

  // Cap on the number of terms of one expansion
  localparam int unsigned MaxTerms = 47;
  localparam int unsigned TermCntW = $clog2(MaxTerms);

  typedef struct packed {
    logic [FieldW-1:0] numerator;
    logic [FieldW-1:0] denominator;
  } cfe_req_t;

  typedef struct packed {
    logic [FieldW-1:0] term;
    logic              last;
    logic              div_error;
  } cfe_res_t;

  typedef enum logic {
    StIdle,
    StDivide
  } cfe_state_e;

endpackage

// ===== src/cfe_div.sv =====
module cfe_div #(
  parameter int unsigned WIDTH = cfe_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;

  // Shift in the next dividend bit and try one subtraction
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(WIDTH);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      // Keep the difference when it does not go negative
      if (!trial[WIDTH]) begin
        rem_d = trial[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== src/continued_fraction_expander.sv =====
// Continued fraction expander.
// Request channel: req_i carries numerator and denominator; a request is taken
// at a rising edge where start is high and busy is low. busy stays high while
// an expansion runs, so one request is worked on at a time.
// Result channel: each term appears on res_o for exactly one cycle, flagged by
// res_valid_o. The receiver cannot hold results off and must take every term.
// The final term of a fraction has last set. A zero denominator gives one
// result with term 0, last 1 and div_error 1, in the cycle after the request,
// and busy does not rise.
// Terms: every term comes from one shift-subtract division in the shared
// divider, one quotient bit per cycle. At WIDTH 32 the worst case is 46
// terms. At most 47 terms are produced.
// Reset: asynchronous, active low; it returns the block to idle and drops
// any expansion in progress.
module continued_fraction_expander #(
  parameter int unsigned WIDTH = cfe_pkg::DefaultWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cfe_pkg::cfe_req_t req_i,
  output logic              res_valid_o,
  output cfe_pkg::cfe_res_t res_o
);

  cfe_pkg::cfe_state_e state_q, state_d;

  logic [cfe_pkg::TermCntW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0]             dvs_q, dvs_d;
  logic                         res_valid_q, res_valid_d;
  cfe_pkg::cfe_res_t            res_q, res_d;

  logic             accept;
  logic [WIDTH-1:0] num_w;
  logic [WIDTH-1:0] den_w;
  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic             div_done;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;
  logic             term_end;

  // Take the request fields at the working width
  assign accept = start && (state_q == cfe_pkg::StIdle);
  assign num_w  = WIDTH'(req_i.numerator);
  assign den_w  = WIDTH'(req_i.denominator);

  assign term_end = (div_rem == '0) ||
                    (cnt_q == cfe_pkg::TermCntW'(cfe_pkg::MaxTerms - 1));

  cfe_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequence the divisions and emit one term per finished division
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    dvs_d        = dvs_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = num_w;
    div_divisor  = den_w;
    unique case (state_q)
      cfe_pkg::StIdle: begin
        if (accept) begin
          if (den_w == '0) begin
            res_valid_d     = 1'b1;
            res_d.term      = '0;
            res_d.last      = 1'b1;
            res_d.div_error = 1'b1;
          end else begin
            div_start = 1'b1;
            dvs_d     = den_w;
            cnt_d     = '0;
            state_d   = cfe_pkg::StDivide;
          end
        end
      end
      cfe_pkg::StDivide: begin
        if (div_done) begin
          res_valid_d     = 1'b1;
          res_d.term      = cfe_pkg::FieldW'(div_quo);
          res_d.last      = term_end;
          res_d.div_error = 1'b0;
          cnt_d           = cnt_q + cfe_pkg::TermCntW'(1);
          if (term_end) begin
            state_d = cfe_pkg::StIdle;
          end else begin
            // Advance the pair to (divisor, remainder)
            div_start    = 1'b1;
            div_dividend = dvs_q;
            div_divisor  = div_rem;
            dvs_d        = div_rem;
          end
        end
      end
      default: begin
        state_d = cfe_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfe_pkg::StIdle;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != cfe_pkg::StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/cfe_checker.sv =====
module cfe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input cfe_pkg::cfe_req_t req_i,
  input logic              res_valid_o,
  input cfe_pkg::cfe_res_t res_o
);

  // An error result is a single zero term that closes the fraction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.div_error |-> res_o.last && (res_o.term == '0))
    else $error("error result is not a closing zero term");

  // A zero denominator is answered on the next cycle with an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.denominator == '0) |=>
      res_valid_o && res_o.div_error && !busy)
    else $error("zero denominator not reported");

  // More terms follow a term without last, so the block stays busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("expansion dropped before its last term");

  // The block goes idle only together with the last term
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.last && !res_o.div_error)
    else $error("busy fell without a last term");

endmodule

bind continued_fraction_expander cfe_checker u_cfe_checker (.*);
